@@ hw/rtl/solpf_pkg.sv @@
// ----------------------------------------------------------------------------
// solpf_pkg: shared definitions for the second-order low-pass filter
// Widths, register indexes, sequencer states and the control bundle that the
// top level hands to the two serial multiply units.
// ----------------------------------------------------------------------------
package solpf_pkg;

  // Default parameter values.
  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int COEF_FRAC_BITS_DEF = 24;

  // Coefficient registers are always 32-bit signed fixed point.
  localparam int COEF_W = 32;

  // Bit counter for one pass over a coefficient.
  localparam int CNT_W = $clog2(COEF_W);

  // Headroom bits above the sample width in the feedback accumulator.
  localparam int ACC_GUARD_BITS = 5;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_SCALE        = 2'd0,
    REG_COEF_FEEDBACK_ONE = 2'd1,
    REG_COEF_FEEDBACK_TWO = 2'd2,
    REG_COEF_FORWARD      = 2'd3
  } solpf_reg_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_SLOAD,
    ST_SCALE,
    ST_DONE
  } solpf_state_t;

  // Control for one serial multiply unit.
  typedef struct packed {
    logic load;       // capture operands and clear the product
    logic step;       // consume one coefficient bit
    logic sign_step;  // the bit being consumed is the coefficient sign bit
  } solpf_ctl_t;

endpackage

@@ hw/rtl/second_order_lowpass_filter.sv @@
// ----------------------------------------------------------------------------
// second_order_lowpass_filter: fixed-point bilinear low-pass biquad
// Computes y = k0*(k1*y1 + k2*y2 + k3*(x + 2*x1 + x2)) per sample with
// bit-serial multipliers, rounding half up and saturating to the sample width.
// ----------------------------------------------------------------------------
// Each sample passes through these steps from one input transfer to the next:
// accept, a pass in which the 32-bit feedback and forward coefficients are
// shifted through the first serial multiplier one bit per cycle, hand the sum
// over, a pass for the overall scale k0 in the second serial multiplier, and
// round, saturate and load the output register once it is free.
// The output register lets
// the next sample be accepted while a result waits for its transfer. The
// coefficients are signed with COEF_FRAC_BITS fraction bits, reset to zero and
// should be written while the filter is idle; a write to them does not disturb
// the history taps, which clear at reset or through the clear flag of a sample.
// ----------------------------------------------------------------------------
module second_order_lowpass_filter #(
  parameter int SAMPLE_BITS    = solpf_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = solpf_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [SAMPLE_BITS-1:0]          in_sample_in,
  input  logic                            in_clear_history,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [SAMPLE_BITS-1:0]          out_sample_out,
  // Configuration port
  input  logic                            cfg_wr_en,
  input  logic [solpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [solpf_pkg::COEF_W-1:0]    cfg_data
);
  import solpf_pkg::*;

  localparam int ACC_W = SAMPLE_BITS + ACC_GUARD_BITS + COEF_W;

  solpf_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [COEF_W-1:0] coef_scale_r, coef_fb1_r, coef_fb2_r, coef_fwd_r;

  solpf_ctl_t mac_ctl, scl_ctl;
  logic       in_fire, res_load, last_bit;

  logic [SAMPLE_BITS-1:0] y1_eff, y2_eff, y_res;
  logic [SAMPLE_BITS+1:0] sum_eff;
  logic [ACC_W-1:0]       acc;

  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_sample_r;

  // Coefficient registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_scale_r <= '0;
      coef_fb1_r   <= '0;
      coef_fb2_r   <= '0;
      coef_fwd_r   <= '0;
    end else if (cfg_wr_en) begin
      case (solpf_reg_t'(cfg_index))
        REG_COEF_SCALE:        coef_scale_r <= cfg_data;
        REG_COEF_FEEDBACK_ONE: coef_fb1_r   <= cfg_data;
        REG_COEF_FEEDBACK_TWO: coef_fb2_r   <= cfg_data;
        REG_COEF_FORWARD:      coef_fwd_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer state and bit counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign last_bit = (cnt_r == CNT_W'(COEF_W - 1));
  assign in_fire  = in_valid && in_ready;

  // Next state and unit controls.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    res_load  = 1'b0;
    mac_ctl   = '0;
    scl_ctl   = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mac_ctl.load = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = ST_MAC;
        end
      end
      ST_MAC: begin
        mac_ctl.step      = 1'b1;
        mac_ctl.sign_step = last_bit;
        cnt_nxt           = cnt_r + 1'b1;
        if (last_bit) begin
          state_nxt = ST_SLOAD;
        end
      end
      ST_SLOAD: begin
        scl_ctl.load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_SCALE;
      end
      ST_SCALE: begin
        scl_ctl.step      = 1'b1;
        scl_ctl.sign_step = last_bit;
        cnt_nxt           = cnt_r + 1'b1;
        if (last_bit) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  solpf_history #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_history (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_fire),
    .sample (in_sample_in),
    .clear  (in_clear_history),
    .y_wr   (res_load),
    .y_new  (y_res),
    .y1_eff (y1_eff),
    .y2_eff (y2_eff),
    .sum_eff(sum_eff)
  );

  solpf_mac #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_mac (
    .clk     (clk),
    .ctl     (mac_ctl),
    .coef_fb1(coef_fb1_r),
    .coef_fb2(coef_fb2_r),
    .coef_fwd(coef_fwd_r),
    .y1      (y1_eff),
    .y2      (y2_eff),
    .sum     (sum_eff),
    .acc     (acc)
  );

  solpf_scale #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_scale (
    .clk       (clk),
    .ctl       (scl_ctl),
    .coef_scale(coef_scale_r),
    .acc       (acc),
    .y         (y_res)
  );

  // Output register; a finished result waits here for its transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_sample_r <= y_res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  // An accepted sample always starts the feedback pass.
  a_accept_starts_mac: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_MAC))
    else $error("accepted sample did not start the feedback pass");

  // A finished result is never held back once the output register is free.
  a_done_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && (!out_valid_r || out_ready)) |=> out_valid_r)
    else $error("finished result was not loaded into the output register");

  // A new result only appears at the end of a sample's computation.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result appeared outside the final sequencer state");

endmodule

@@ hw/rtl/solpf_history.sv @@
// ----------------------------------------------------------------------------
// solpf_history: input and output delay taps
// Holds x1, x2, y1, y2, applies the clear flag and forms the operands of the
// feedback pass for the sample being accepted.
// ----------------------------------------------------------------------------
module solpf_history #(
  parameter int SAMPLE_BITS = solpf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   clear,
  input  logic                   y_wr,
  input  logic [SAMPLE_BITS-1:0] y_new,
  output logic [SAMPLE_BITS-1:0] y1_eff,
  output logic [SAMPLE_BITS-1:0] y2_eff,
  output logic [SAMPLE_BITS+1:0] sum_eff
);
  import solpf_pkg::*;

  logic [SAMPLE_BITS-1:0] x1_r, x2_r, y1_r, y2_r;
  logic [SAMPLE_BITS-1:0] x1_eff, x2_eff;

  // A clear makes the current sample see zero history.
  assign x1_eff = clear ? '0 : x1_r;
  assign x2_eff = clear ? '0 : x2_r;
  assign y1_eff = clear ? '0 : y1_r;
  assign y2_eff = clear ? '0 : y2_r;

  // Forward input sum x + 2*x1 + x2, sign-extended to its full width.
  assign sum_eff = {{2{sample[SAMPLE_BITS-1]}}, sample}
                 + {x1_eff[SAMPLE_BITS-1], x1_eff, 1'b0}
                 + {{2{x2_eff[SAMPLE_BITS-1]}}, x2_eff};

  // Input taps shift on a transfer; output taps shift when the result is final.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r <= '0;
      x2_r <= '0;
      y1_r <= '0;
      y2_r <= '0;
    end else if (accept) begin
      x1_r <= sample;
      x2_r <= x1_eff;
      y1_r <= y1_eff;
      y2_r <= y2_eff;
    end else if (y_wr) begin
      y1_r <= y_new;
      y2_r <= y1_r;
    end
  end

endmodule

@@ hw/rtl/solpf_mac.sv @@
// ----------------------------------------------------------------------------
// solpf_mac: bit-serial feedback and forward multiply-accumulate
// Forms k1*y1 + k2*y2 + k3*sum with the three coefficients shifted out one
// bit per cycle, least significant first, into a shared accumulator.
// ----------------------------------------------------------------------------
module solpf_mac #(
  parameter int SAMPLE_BITS = solpf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  solpf_pkg::solpf_ctl_t        ctl,
  input  logic [solpf_pkg::COEF_W-1:0] coef_fb1,
  input  logic [solpf_pkg::COEF_W-1:0] coef_fb2,
  input  logic [solpf_pkg::COEF_W-1:0] coef_fwd,
  input  logic [SAMPLE_BITS-1:0]       y1,
  input  logic [SAMPLE_BITS-1:0]       y2,
  input  logic [SAMPLE_BITS+1:0]       sum,
  output logic [SAMPLE_BITS+solpf_pkg::ACC_GUARD_BITS+solpf_pkg::COEF_W-1:0] acc
);
  import solpf_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + 2;
  localparam int HI_W  = SAMPLE_BITS + ACC_GUARD_BITS;
  localparam int ACC_W = HI_W + COEF_W;

  logic [COEF_W-1:0]      k1_r, k2_r, k3_r;
  logic [SAMPLE_BITS-1:0] y1_r, y2_r;
  logic [SUM_W-1:0]       sum_r;
  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic [HI_W-1:0]        term, top;

  // Partial product for this bit; the sign bit carries negative weight.
  always_comb begin
    term = '0;
    if (k1_r[0]) begin
      term = term + {{(HI_W-SAMPLE_BITS){y1_r[SAMPLE_BITS-1]}}, y1_r};
    end
    if (k2_r[0]) begin
      term = term + {{(HI_W-SAMPLE_BITS){y2_r[SAMPLE_BITS-1]}}, y2_r};
    end
    if (k3_r[0]) begin
      term = term + {{(HI_W-SUM_W){sum_r[SUM_W-1]}}, sum_r};
    end
    if (ctl.sign_step) begin
      term = -term;
    end
    top     = acc_r[ACC_W-1 -: HI_W] + term;
    acc_nxt = {top[HI_W-1], top, acc_r[COEF_W-1:1]};
  end

  // Operand capture and one shift-add per cycle while stepping.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      k1_r  <= coef_fb1;
      k2_r  <= coef_fb2;
      k3_r  <= coef_fwd;
      y1_r  <= y1;
      y2_r  <= y2;
      sum_r <= sum;
      acc_r <= '0;
    end else if (ctl.step) begin
      k1_r  <= {1'b0, k1_r[COEF_W-1:1]};
      k2_r  <= {1'b0, k2_r[COEF_W-1:1]};
      k3_r  <= {1'b0, k3_r[COEF_W-1:1]};
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

@@ hw/rtl/solpf_scale.sv @@
// ----------------------------------------------------------------------------
// solpf_scale: bit-serial overall scale, rounding and saturation
// Multiplies the accumulated sum by k0 one coefficient bit per cycle, then
// rounds half up to an integer sample and clamps it to the sample range.
// ----------------------------------------------------------------------------
module solpf_scale #(
  parameter int SAMPLE_BITS    = solpf_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = solpf_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  solpf_pkg::solpf_ctl_t        ctl,
  input  logic [solpf_pkg::COEF_W-1:0] coef_scale,
  input  logic [SAMPLE_BITS+solpf_pkg::ACC_GUARD_BITS+solpf_pkg::COEF_W-1:0] acc,
  output logic [SAMPLE_BITS-1:0]       y
);
  import solpf_pkg::*;

  localparam int ACC_W  = SAMPLE_BITS + ACC_GUARD_BITS + COEF_W;
  localparam int HI_W   = ACC_W + 1;
  localparam int PROD_W = HI_W + COEF_W;
  localparam int SHIFT  = 2 * COEF_FRAC_BITS;
  localparam int QW     = PROD_W - SHIFT;
  localparam int RND_W  = QW + 1;
  localparam int UP_W   = RND_W - SAMPLE_BITS + 1;

  logic [COEF_W-1:0] k0_r;
  logic [ACC_W-1:0]  mult_r;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [HI_W-1:0]   term, top;
  logic [QW-1:0]     quot;
  logic [RND_W-1:0]  rnd;
  logic [UP_W-1:0]   upper;

  // Shift-add step; the coefficient sign bit subtracts.
  always_comb begin
    term = '0;
    if (k0_r[0]) begin
      term = {mult_r[ACC_W-1], mult_r};
    end
    if (ctl.sign_step) begin
      term = -term;
    end
    top      = prod_r[PROD_W-1 -: HI_W] + term;
    prod_nxt = {top[HI_W-1], top, prod_r[COEF_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      k0_r   <= coef_scale;
      mult_r <= acc;
      prod_r <= '0;
    end else if (ctl.step) begin
      k0_r   <= {1'b0, k0_r[COEF_W-1:1]};
      prod_r <= prod_nxt;
    end
  end

  // Round half up: drop the fraction and add its top bit.
  assign quot  = prod_r[PROD_W-1:SHIFT];
  assign rnd   = {quot[QW-1], quot} + {{QW{1'b0}}, prod_r[SHIFT-1]};
  assign upper = rnd[RND_W-1:SAMPLE_BITS-1];

  // Clamp to the signed sample range.
  always_comb begin
    if ((&upper) || !(|upper)) begin
      y = rnd[SAMPLE_BITS-1:0];
    end else if (rnd[RND_W-1]) begin
      y = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      y = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

endmodule
